// ===== hw/rtl/tty_pkg.sv =====
// Package: constants and types for the tty line discipline.
package tty_pkg;
    localparam int RING_DEPTH = 4096;
    localparam int LINE_DEPTH = 256;
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int LINE_AW = $clog2(LINE_DEPTH);

    typedef logic [RING_AW-1:0] t_rptr;
    typedef logic [LINE_AW-1:0] t_lptr;

    typedef enum logic [1:0] {
        REQ_KEY     = 2'd0,
        REQ_SHOUT   = 2'd1,
        REQ_TRD     = 2'd2,
        REQ_SRD     = 2'd3
    } t_req;

    localparam logic [1:0] CFG_RAW  = 2'd0;
    localparam logic [1:0] CFG_ECHO = 2'd1;
    localparam logic [1:0] CFG_FG   = 2'd2;

    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CAR = 8'h5E;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_DEL = 8'h7F;
endpackage

// ===== hw/rtl/tty_ring.sv =====
// Byte ring: one memory with head/tail pointers, push and registered pop.
module tty_ring (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_push_data,
    input  logic             i_pop,
    output logic [7:0]       o_pop_data,
    output tty_pkg::t_rptr   o_used,
    output tty_pkg::t_rptr   o_room
);
    import tty_pkg::*;

    logic [7:0] r_mem [RING_DEPTH];
    t_rptr r_head, r_tail;

    assign o_used = r_head - r_tail;
    assign o_room = t_rptr'(RING_DEPTH - 1) - o_used;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_head] <= i_push_data;
        end
        o_pop_data <= r_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_push) begin
                r_head <= r_head + t_rptr'(1);
            end
            if (i_pop) begin
                r_tail <= r_tail + t_rptr'(1);
            end
        end
    end
endmodule

// ===== hw/rtl/tty_line_discipline.sv =====
// Top level: tty line discipline with edit line and two byte rings.
// Flow: an accepted item passes S_ECHO (echo bytes to the output ring), S_COMMIT
// for a line commit, then S_DONE for the result; a read passes S_READ (pop,
// registered memory read) then S_DONE. One item at a time: the next is accepted
// only after the result is taken; a line commit copies the edit line one byte
// per cycle into the input ring.
// Reset (synchronous, active low) clears pointers, lengths and control state; echo resets on.
module tty_line_discipline (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    output logic       o_interrupt_request,
    output logic       o_byte_dropped,
    output logic       o_terminal_readable,
    output logic       o_shell_readable
);
    import tty_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ECHO, S_COMMIT, S_READ, S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_req;
    logic [7:0] r_data;
    logic r_raw, r_echo, r_fg;
    t_lptr r_elen;
    logic [LINE_AW:0] r_idx;
    logic [7:0] r_eq [4];
    logic [2:0] r_eq_n, r_eq_i;
    logic r_commit, r_lf_only, r_lost, r_intr, r_first;

    logic [7:0] r_line [LINE_DEPTH];
    logic [7:0] r_line_q;
    t_lptr line_raddr;

    logic in_push, out_push, in_pop, out_pop;
    logic [7:0] in_wd, out_wd, in_rd, out_rd;
    t_rptr in_used, in_room, out_used, out_room;

    tty_ring u_in (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(in_push), .i_push_data(in_wd),
        .i_pop(in_pop), .o_pop_data(in_rd),
        .o_used(in_used), .o_room(in_room)
    );
    tty_ring u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(out_push), .i_push_data(out_wd),
        .i_pop(out_pop), .o_pop_data(out_rd),
        .o_used(out_used), .o_room(out_room)
    );

    assign o_stall = (r_state != S_IDLE) || o_valid;

    logic is_print;
    assign is_print = (i_data_byte >= CH_SP) && (i_data_byte < CH_DEL);

    // echo queue drain: one byte per cycle into the output ring
    logic echo_go;
    assign echo_go = (r_state == S_ECHO) && (r_eq_i != r_eq_n);
    logic commit_copy;
    assign commit_copy = (r_state == S_COMMIT) && !r_first;
    assign line_raddr = r_idx[LINE_AW-1:0];

    always_comb begin
        out_push = 1'b0;
        out_wd = r_eq[r_eq_i[1:0]];
        in_push = 1'b0;
        in_wd = r_line_q;
        if (echo_go) begin
            out_push = (out_room != '0);
        end
        if (commit_copy) begin
            in_push = 1'b1;
            if (r_idx == {1'b0, r_elen} + 1'b1) begin
                in_wd = CH_LF;
            end
        end
        if (r_state == S_ECHO && r_eq_i == r_eq_n && r_lf_only) begin
            in_push = (in_room != '0);
            in_wd = CH_LF;
        end
        if (r_state == S_ECHO && r_eq_i == r_eq_n && r_req == REQ_KEY && r_raw) begin
            in_push = (in_room != '0);
            in_wd = r_data;
        end
    end

    assign in_pop = (r_state == S_READ) && r_first && (r_req == REQ_SRD) && (in_used != '0);
    assign out_pop = (r_state == S_READ) && r_first && (r_req == REQ_TRD) && (out_used != '0);

    always_ff @(posedge i_clk) begin
        r_line_q <= r_line[line_raddr];
        if (i_valid && !o_stall && i_req_type == REQ_KEY && !r_raw && is_print
            && r_elen != t_lptr'(LINE_DEPTH - 1)) begin
            r_line[r_elen] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_raw <= 1'b0;
            r_echo <= 1'b1;
            r_fg <= 1'b0;
            r_elen <= '0;
            o_valid <= 1'b0;
            r_eq_n <= '0;
            r_eq_i <= '0;
            r_commit <= 1'b0;
            r_lf_only <= 1'b0;
            r_first <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RAW: begin
                        r_raw <= i_cfg_data;
                        if (!i_cfg_data) r_elen <= '0;
                    end
                    CFG_ECHO: r_echo <= i_cfg_data;
                    CFG_FG:   r_fg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req <= i_req_type;
                        r_data <= i_data_byte;
                        r_lost <= 1'b0;
                        r_intr <= 1'b0;
                        r_eq_i <= '0;
                        r_eq_n <= '0;
                        r_commit <= 1'b0;
                        r_lf_only <= 1'b0;
                        r_first <= 1'b1;
                        o_read_byte <= '0;
                        o_read_valid <= 1'b0;
                        r_state <= S_ECHO;
                        unique case (i_req_type)
                            REQ_KEY: begin
                                if (r_raw) begin
                                    // raw key is stored from S_ECHO
                                end else if (i_data_byte == CH_CR
                                             || i_data_byte == CH_LF) begin
                                    r_eq[0] <= CH_CR;
                                    r_eq[1] <= CH_LF;
                                    r_eq_n <= r_echo ? 3'd2 : 3'd0;
                                    r_commit <= 1'b1;
                                end else if (i_data_byte == CH_BS
                                             || i_data_byte == CH_DEL) begin
                                    if (r_elen != '0) begin
                                        r_elen <= r_elen - t_lptr'(1);
                                        r_eq[0] <= CH_BS;
                                        r_eq[1] <= CH_SP;
                                        r_eq[2] <= CH_BS;
                                        r_eq_n <= r_echo ? 3'd3 : 3'd0;
                                    end
                                end else if (i_data_byte == CH_ETX) begin
                                    r_elen <= '0;
                                    r_eq[0] <= CH_CAR;
                                    r_eq[1] <= CH_C;
                                    r_eq[2] <= CH_CR;
                                    r_eq[3] <= CH_LF;
                                    r_eq_n <= r_echo ? 3'd4 : 3'd0;
                                    r_intr <= r_fg;
                                end else if (i_data_byte == CH_EOT) begin
                                    if (r_elen == '0) begin
                                        r_eq[0] <= CH_CR;
                                        r_eq[1] <= CH_LF;
                                        r_eq_n <= r_echo ? 3'd2 : 3'd0;
                                        r_lf_only <= 1'b1;
                                    end else begin
                                        r_commit <= 1'b1;
                                    end
                                end else if (is_print) begin
                                    if (r_elen != t_lptr'(LINE_DEPTH - 1))
                                        r_elen <= r_elen + t_lptr'(1);
                                    r_eq[0] <= i_data_byte;
                                    r_eq_n <= r_echo ? 3'd1 : 3'd0;
                                end
                            end
                            REQ_SHOUT: begin
                                if (!r_raw && i_data_byte == CH_LF) begin
                                    r_eq[0] <= CH_CR;
                                    r_eq[1] <= CH_LF;
                                    r_eq_n <= 3'd2;
                                end else begin
                                    r_eq[0] <= i_data_byte;
                                    r_eq_n <= 3'd1;
                                end
                            end
                            default: r_state <= S_READ;
                        endcase
                    end
                end
                S_ECHO: begin
                    if (echo_go) begin
                        if (out_room == '0) r_lost <= 1'b1;
                        r_eq_i <= r_eq_i + 3'd1;
                    end else begin
                        if (r_lf_only) begin
                            if (in_room == '0) r_lost <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_req == REQ_KEY && r_raw) begin
                            if (in_room == '0) r_lost <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_commit) begin
                            if (({5'd0, r_elen} + 13'd1) > {1'b0, in_room}) begin
                                r_lost <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= '0;
                                r_first <= 1'b1;
                                r_state <= S_COMMIT;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_COMMIT: begin
                    r_first <= 1'b0;
                    if (r_idx <= {1'b0, r_elen}) r_idx <= r_idx + 1'b1;
                    if (commit_copy && r_idx == {1'b0, r_elen} + 1'b1) begin
                        r_elen <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_first <= 1'b0;
                    if (!r_first) begin
                        o_read_byte <= (r_req == REQ_SRD) ? in_rd : out_rd;
                        o_read_valid <= r_lf_only;
                        r_state <= S_DONE;
                    end else begin
                        r_lf_only <= (r_req == REQ_SRD) ? (in_used != '0)
                                                        : (out_used != '0);
                    end
                end
                S_DONE: begin
                    if (!o_read_valid) o_read_byte <= '0;
                    o_interrupt_request <= r_intr;
                    o_byte_dropped <= r_lost;
                    o_terminal_readable <= (out_used != '0);
                    o_shell_readable <= (in_used != '0) || (r_elen != '0);
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_push |-> (in_room != '0 || commit_copy))
        else $error("input ring overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("item accepted while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> !r_raw)
        else $error("commit in raw mode");
endmodule
